@@ rtl/core/fpd_pkg.sv @@
// ============================================================================
// fpd_pkg: shared types and constants for the saturating 16.16 divider
// Defines the transaction payloads and the per-stage record handed down the
// divider cell row.
// ============================================================================
package fpd_pkg;

    localparam int WORD_W  = 32;
    localparam int FRAC_W  = 16;
    localparam int GUARD_W = 14;
    // The guard keeps the quotient magnitude below 2^(WORD_W - 2).
    localparam int QUO_W   = WORD_W - 2;
    localparam int REM_W   = WORD_W - 1;
    localparam int NUM_CELLS = QUO_W;

    localparam logic [WORD_W-1:0] SAT_NEG = 32'h8000_0000;
    localparam logic [WORD_W-1:0] SAT_POS = 32'h7FFF_FFFF;

    typedef struct packed {
        logic signed [WORD_W-1:0] dividend;
        logic signed [WORD_W-1:0] divisor;
    } t_fpd_in;

    typedef struct packed {
        logic signed [WORD_W-1:0] quotient;
        logic                     saturated;
    } t_fpd_out;

    typedef struct packed {
        logic              valid;
        logic              sat;
        logic              neg;
        logic [WORD_W-1:0] mb;
        logic [REM_W-1:0]  rem;
        logic [QUO_W-1:0]  nbits;
        logic [QUO_W-1:0]  quo;
    } t_fpd_stage;

endpackage

@@ rtl/core/fpd_front.sv @@
// ============================================================================
// fpd_front: operand conditioning stage
// Forms exact magnitudes, evaluates the overflow guard and loads the first
// partial remainder for the cell row.
// ============================================================================
module fpd_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  fpd_pkg::t_fpd_in   i_data,
    output fpd_pkg::t_fpd_stage o_stage
);
    import fpd_pkg::*;

    logic [WORD_W-1:0] ma;
    logic [WORD_W-1:0] mb;
    logic              guard;
    t_fpd_stage        n_stage;
    t_fpd_stage        r_stage;

    // Negation in the unsigned domain keeps -2^31 at magnitude 2^31.
    assign ma = i_data.dividend[WORD_W-1] ? (~i_data.dividend + 1'b1) : i_data.dividend;
    assign mb = i_data.divisor[WORD_W-1] ? (~i_data.divisor + 1'b1) : i_data.divisor;
    assign guard = {{GUARD_W{1'b0}}, ma[WORD_W-1:GUARD_W]} >= mb;

    always_comb begin
        n_stage       = '0;
        n_stage.valid = i_valid;
        n_stage.sat   = guard;
        n_stage.neg   = i_data.dividend[WORD_W-1] ^ i_data.divisor[WORD_W-1];
        n_stage.mb    = mb;
        // The numerator is ma << FRAC_W; its top bits seed the remainder and
        // the rest are shifted in one per cell.
        n_stage.rem   = {{(REM_W - (WORD_W - GUARD_W)){1'b0}}, ma[WORD_W-1:GUARD_W]};
        n_stage.nbits = {ma[GUARD_W-1:0], {FRAC_W{1'b0}}};
        n_stage.quo   = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

@@ rtl/core/fpd_cell.sv @@
// ============================================================================
// fpd_cell: one restoring division step
// Shifts the next numerator bit into the remainder, trial-subtracts the
// divisor magnitude and appends one quotient bit.
// ============================================================================
module fpd_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  fpd_pkg::t_fpd_stage i_stage,
    output fpd_pkg::t_fpd_stage o_stage
);
    import fpd_pkg::*;

    logic [WORD_W-1:0] trial;
    logic [WORD_W:0]   diff;
    logic              q_bit;
    t_fpd_stage        n_stage;
    t_fpd_stage        r_stage;

    assign trial = {i_stage.rem, i_stage.nbits[QUO_W-1]};
    assign diff  = {1'b0, trial} - {1'b0, i_stage.mb};
    assign q_bit = ~diff[WORD_W];

    always_comb begin
        n_stage       = i_stage;
        n_stage.rem   = q_bit ? diff[REM_W-1:0] : trial[REM_W-1:0];
        n_stage.nbits = {i_stage.nbits[QUO_W-2:0], 1'b0};
        n_stage.quo   = {i_stage.quo[QUO_W-2:0], q_bit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

@@ rtl/core/fpd_back.sv @@
// ============================================================================
// fpd_back: sign restore and output register
// Applies the result sign or the saturation value and holds the finished
// transaction until the consumer takes it.
// ============================================================================
module fpd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  fpd_pkg::t_fpd_stage i_stage,
    output logic                o_valid,
    output fpd_pkg::t_fpd_out   o_data
);
    import fpd_pkg::*;

    logic [WORD_W-1:0] mag;
    t_fpd_out          n_data;
    t_fpd_out          r_data;
    logic              r_valid;

    assign mag = {{(WORD_W - QUO_W){1'b0}}, i_stage.quo};

    always_comb begin
        if (i_stage.sat) begin
            n_data.quotient  = i_stage.neg ? SAT_NEG : SAT_POS;
            n_data.saturated = 1'b1;
        end else begin
            n_data.quotient  = i_stage.neg ? (~mag + 1'b1) : mag;
            n_data.saturated = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_stage.valid;
            r_data  <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ rtl/core/fixed_point_divide_16_16_sat_top.sv @@
// ============================================================================
// fixed_point_divide_16_16_sat_top: saturating signed 16.16 divider
// The pipeline is one conditioning stage, a row of 30 restoring
// division cells (one quotient bit each) and the output register.
// Throughput is one transaction per cycle; the whole row advances together
// and holds while a finished result waits at the output.
// Synchronous active-low reset clears all stage valid flags.
// ============================================================================
module fixed_point_divide_16_16_sat_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  fpd_pkg::t_fpd_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output fpd_pkg::t_fpd_out o_out_data
);
    import fpd_pkg::*;

    logic       en;
    t_fpd_stage stage [NUM_CELLS+1];

    // The row moves whenever the output slot is free or being emptied.
    assign en         = ~o_out_valid | i_out_ready;
    assign o_in_ready = en;

    fpd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .o_stage (stage[0])
    );

    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        fpd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_stage (stage[k]),
            .o_stage (stage[k+1])
        );
    end

    fpd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_stage (stage[NUM_CELLS]),
        .o_valid (o_out_valid),
        .o_data  (o_out_data)
    );

endmodule

@@ tb/tb_fixed_point_divide_16_16_sat_top.sv @@
// ============================================================================
// tb_fixed_point_divide_16_16_sat_top: self-checking bench for the divider
// Drives a table of directed operand pairs (signs, extremes, zero divisors,
// the saturation boundary), then random operands shaped toward the guard
// region. Every accepted transaction gets an expected quotient, either typed
// in the table or computed by an exact integer divider in the bench, and
// each output transaction is compared in order. Both sides idle at random.
// ============================================================================
module tb_fixed_point_divide_16_16_sat_top;
    import fpd_pkg::*;

    localparam int RANDOM_ITEMS   = 825;
    localparam int MAX_IDLE       = 12;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int MAX_REPORTS    = 10;

    localparam logic TYPED     = 1'b1;
    localparam logic PREDICTED = 1'b0;

    localparam logic [WORD_W-1:0] WORD_MIN = 32'h8000_0000;
    localparam logic [WORD_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] ONE_FX   = 32'h0001_0000;
    localparam logic [WORD_W-1:0] M_ONE_FX = 32'hFFFF_0000;

    typedef struct packed {
        logic [WORD_W-1:0] dividend;
        logic [WORD_W-1:0] divisor;
        logic              typed;
        logic [WORD_W-1:0] quotient;
        logic              saturated;
    } t_div_row;

    localparam int NUM_DIRECTED = 25;
    localparam t_div_row DIRECTED [NUM_DIRECTED] = '{
        '{32'h0000_0000, ONE_FX,        TYPED,     32'h0000_0000, 1'b0},
        '{ONE_FX,        ONE_FX,        TYPED,     ONE_FX,        1'b0},
        '{M_ONE_FX,      ONE_FX,        TYPED,     M_ONE_FX,      1'b0},
        '{ONE_FX,        M_ONE_FX,      TYPED,     M_ONE_FX,      1'b0},
        '{M_ONE_FX,      M_ONE_FX,      TYPED,     ONE_FX,        1'b0},
        '{32'h1234_5678, 32'h0000_0000, TYPED,     SAT_POS,       1'b1},
        '{32'h0000_0000, 32'h0000_0000, TYPED,     SAT_POS,       1'b1},
        '{WORD_MIN,      32'h0000_0000, TYPED,     SAT_NEG,       1'b1},
        '{32'hFFFF_FFFF, 32'h0000_0000, TYPED,     SAT_NEG,       1'b1},
        '{WORD_MAX,      32'h0000_0001, TYPED,     SAT_POS,       1'b1},
        '{WORD_MIN,      32'hFFFF_FFFF, TYPED,     SAT_POS,       1'b1},
        '{WORD_MIN,      32'h0000_0001, TYPED,     SAT_NEG,       1'b1},
        '{WORD_MAX,      WORD_MIN,      PREDICTED, 32'h0,         1'b0},
        '{WORD_MIN,      WORD_MIN,      TYPED,     ONE_FX,        1'b0},
        '{WORD_MIN,      WORD_MAX,      PREDICTED, 32'h0,         1'b0},
        '{WORD_MAX,      WORD_MAX,      TYPED,     ONE_FX,        1'b0},
        '{32'h0001_4000, 32'h0000_0005, TYPED,     SAT_POS,       1'b1},
        '{32'h0001_3FFF, 32'h0000_0005, PREDICTED, 32'h0,         1'b0},
        '{32'hFFFE_C000, 32'h0000_0005, TYPED,     SAT_NEG,       1'b1},
        '{32'h0000_0001, WORD_MAX,      TYPED,     32'h0000_0000, 1'b0},
        '{32'hFFFF_FFFF, WORD_MAX,      TYPED,     32'h0000_0000, 1'b0},
        '{WORD_MIN,      32'h0002_0001, PREDICTED, 32'h0,         1'b0},
        '{WORD_MAX,      32'h0002_0000, PREDICTED, 32'h0,         1'b0},
        '{32'h0000_0000, 32'hFFFF_FFFF, TYPED,     32'h0000_0000, 1'b0},
        '{32'h0001_8000, 32'h0000_8000, TYPED,     32'h0003_0000, 1'b0}
    };

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    logic     in_ready;
    t_fpd_in  in_data   = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    t_fpd_out out_data;

    t_fpd_out pending_quotients [$];
    int       mismatches = 0;
    int       idle_cycles = 0;
    bit       no_gaps = 1'b0;

    fixed_point_divide_16_16_sat_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Exact 16.16 quotient with the overflow clamp, on magnitudes.
    function automatic t_fpd_out sat_divide(input t_fpd_in x);
        logic [WORD_W-1:0]   ma;
        logic [WORD_W-1:0]   mb;
        logic [2*WORD_W-1:0] num;
        logic [2*WORD_W-1:0] uq;
        logic                neg;
        t_fpd_out            r;
        ma  = x.dividend[WORD_W-1] ? (~x.dividend + 1'b1) : x.dividend;
        mb  = x.divisor[WORD_W-1]  ? (~x.divisor + 1'b1)  : x.divisor;
        neg = x.dividend[WORD_W-1] ^ x.divisor[WORD_W-1];
        if ((ma >> GUARD_W) >= mb) begin
            r.quotient  = neg ? SAT_NEG : SAT_POS;
            r.saturated = 1'b1;
        end else begin
            num = {{WORD_W{1'b0}}, ma} << FRAC_W;
            uq  = num / {{WORD_W{1'b0}}, mb};
            r.quotient  = neg ? (~uq[WORD_W-1:0] + 1'b1) : uq[WORD_W-1:0];
            r.saturated = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] pick_extreme();
        case ($urandom_range(0, 6))
            0:       return WORD_MIN;
            1:       return WORD_MAX;
            2:       return 32'h0000_0000;
            3:       return 32'h0000_0001;
            4:       return 32'hFFFF_FFFF;
            5:       return ONE_FX;
            default: return M_ONE_FX;
        endcase
    endfunction

    // Mixes uniform words, scaled magnitudes, pairs around the clamp edge, zero divisors and extremes.
    function automatic t_fpd_in random_operands();
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        t_fpd_in           x;
        case ($urandom_range(0, 9))
            0, 1: begin
                a = $urandom;
                b = $urandom;
            end
            2, 3: begin
                a = $urandom >> $urandom_range(0, 31);
                b = $urandom >> $urandom_range(0, 31);
            end
            4, 5: begin
                b = $urandom_range(1, 32'h0001_FFFF);
                a = (b << GUARD_W) + $urandom_range(0, 2) - 1;
                if ($urandom_range(0, 3) == 0)
                    a = a - $urandom_range(0, 32'h3FFF);
            end
            6: begin
                a = $urandom;
                b = 32'h0000_0000;
            end
            7: begin
                a = pick_extreme();
                b = pick_extreme();
            end
            default: begin
                a = $urandom >> $urandom_range(4, 20);
                b = $urandom >> $urandom_range(4, 20);
            end
        endcase
        if ($urandom_range(0, 1))
            a = ~a + 1'b1;
        if ($urandom_range(0, 1))
            b = ~b + 1'b1;
        x.dividend = a;
        x.divisor  = b;
        return x;
    endfunction

    // Called at a clock edge; returns at the edge where the transaction is taken.
    task automatic issue_division(input t_fpd_in x, input t_fpd_out expected);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= x;
        do @(posedge clk); while (!(in_valid && in_ready));
        pending_quotients.push_back(expected);
    endtask

    task automatic drain_quotients();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_quotients.size() != 0);
    endtask

    initial begin
        t_fpd_in  x;
        t_fpd_out r;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED[i]) begin
            x.dividend = DIRECTED[i].dividend;
            x.divisor  = DIRECTED[i].divisor;
            if (DIRECTED[i].typed) begin
                r.quotient  = DIRECTED[i].quotient;
                r.saturated = DIRECTED[i].saturated;
            end else begin
                r = sat_divide(x);
            end
            issue_division(x, r);
        end
        drain_quotients();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if ($urandom_range(0, 59) == 0)
                no_gaps = ~no_gaps;
            if (n == RANDOM_ITEMS / 2)
                drain_quotients();
            x = random_operands();
            issue_division(x, sat_divide(x));
        end
        in_valid <= 1'b0;

        while (pending_quotients.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (pending_quotients.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("** fixed_point_divide_16_16_sat_top: PASSED **");
        else
            $display("** fixed_point_divide_16_16_sat_top: FAILED **");
        $finish;
    end

    // Result side: a random stall before each transaction.
    initial begin
        int stall;
        while (!rst_n)
            @(posedge clk);
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    always @(posedge clk) begin
        t_fpd_out want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_quotients.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected output transaction: quotient %h saturated %b",
                             out_data.quotient, out_data.saturated);
            end else begin
                want = pending_quotients.pop_front();
                if (out_data.quotient !== want.quotient
                        || out_data.saturated !== want.saturated) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("quotient mismatch: expected %h/%b, got %h/%b",
                                 want.quotient, want.saturated,
                                 out_data.quotient, out_data.saturated);
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("** fixed_point_divide_16_16_sat_top: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

@@ files.f @@
rtl/core/fpd_pkg.sv
rtl/core/fpd_front.sv
rtl/core/fpd_cell.sv
rtl/core/fpd_back.sv
rtl/core/fixed_point_divide_16_16_sat_top.sv
tb/tb_fixed_point_divide_16_16_sat_top.sv
